// ===== sv/ptrs_pkg.sv =====
// Shared definitions for the periodic task ring scheduler.
// Field widths of the item and result beats and the item kind codes.
// No dependencies.
`default_nettype none

package ptrs_pkg;

  localparam int KIND_W    = 2;
  localparam int TIME_W    = 32;
  localparam int TASK_ID_W = 16;
  localparam int COUNT_W   = 8;

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [TIME_W-1:0] time_t;

  localparam kind_t KIND_STEP   = 2'd0;
  localparam kind_t KIND_ADD    = 2'd1;
  localparam kind_t KIND_REMOVE = 2'd2;
  localparam kind_t KIND_QUERY  = 2'd3;

endpackage

`default_nettype wire

// ===== sv/ptrs_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Used for the scheduler's entry store. No dependencies.
`default_nettype none

module ptrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/periodic_task_ring_scheduler.sv =====
// Periodic task ring scheduler: ring of DEPTH task entries in one RAM, driven by a
// small sequencer. Depends on ptrs_pkg and ptrs_ram.
// Add finishes on acceptance; step reads the head entry from RAM, then updates it and
// writes it back, and finishes on acceptance on an empty ring; remove and query read
// one entry per cycle, make a last compare, then give the result. in_stall is high from acceptance
// until the result sits in the output register. Reset clears head, count and out_valid.
`default_nettype none

module periodic_task_ring_scheduler
  import ptrs_pkg::*;
#(
  parameter int DEPTH   = 128,
  parameter int ID_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [KIND_W-1:0]    kind,
  input  wire logic [TIME_W-1:0]    now,
  input  wire logic [TASK_ID_W-1:0] task_id,
  input  wire logic [TIME_W-1:0]    period,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      fired,
  output logic [TASK_ID_W-1:0]      fired_id,
  output logic [TIME_W-1:0]         lateness,
  output logic                      found,
  output logic                      ring_full,
  output logic [COUNT_W-1:0]        entry_count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ENT_W = ID_BITS + 3 * TIME_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_STEP = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]         state;
  logic [PTR_W-1:0]   head;
  logic [CNT_W-1:0]   used;

  // item held while it is worked on
  kind_t              kind_q;
  logic [ID_BITS-1:0] key_q;
  time_t              now_q;

  // walk state
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   keep;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W-1:0]   wr_ptr;
  logic               rd_pend;
  logic               hit;
  time_t              hit_late;

  // result held while the output register is busy
  logic                 res_fired;
  logic [TASK_ID_W-1:0] res_id;
  time_t                res_late;
  logic                 res_found;
  logic                 res_full;
  logic [COUNT_W-1:0]   res_count;

  // RAM port
  logic               ram_we;
  logic [PTR_W-1:0]   ram_wa;
  logic [ENT_W-1:0]   ram_wd;
  logic               ram_re;
  logic [PTR_W-1:0]   ram_ra;
  logic [ENT_W-1:0]   ram_rd;

  logic [ID_BITS-1:0] r_id;
  time_t              r_due;
  time_t              r_per;
  time_t              r_late;

  logic                         accept;
  logic [ID_BITS+TASK_ID_W-1:0] task_ext;
  logic [ID_BITS-1:0]           key_in;
  logic [CNT_W:0]               tail_sum;
  logic [CNT_W:0]               tail_wrap;
  logic [PTR_W-1:0]             tail;
  logic                         step_fire;
  time_t                        step_late;
  time_t                        step_due;
  logic                         walk_issue;
  logic                         walk_match;

  logic                 fin;
  logic                 f_fired;
  logic [ID_BITS-1:0]   f_id_raw;
  time_t                f_late;
  logic                 f_found;
  logic                 f_full;
  logic [CNT_W-1:0]     f_count;
  logic [ID_BITS+TASK_ID_W-1:0] f_id_ext;
  logic [CNT_W+COUNT_W-1:0]     f_count_ext;
  logic                 out_free;
  logic                 load_out;

  ptrs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  assign task_ext = (ID_BITS + TASK_ID_W)'(task_id);
  assign key_in   = task_ext[ID_BITS-1:0];

  // tail slot = (head + used) mod DEPTH, sum stays below 2*DEPTH
  assign tail_sum  = (CNT_W + 1)'(head) + (CNT_W + 1)'(used);
  assign tail_wrap = (tail_sum >= (CNT_W + 1)'(DEPTH)) ?
                     tail_sum - (CNT_W + 1)'(DEPTH) : tail_sum;
  assign tail      = tail_wrap[PTR_W-1:0];

  assign r_id   = ram_rd[ENT_W-1 -: ID_BITS];
  assign r_due  = ram_rd[3*TIME_W-1 -: TIME_W];
  assign r_per  = ram_rd[2*TIME_W-1 -: TIME_W];
  assign r_late = ram_rd[TIME_W-1:0];

  assign step_fire = (now_q >= r_due);
  assign step_late = now_q - r_due;
  assign step_due  = now_q + r_per;

  assign walk_issue = (idx < used);
  assign walk_match = (r_id == key_q);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    ram_we   = 1'b0;
    ram_wa   = tail;
    ram_wd   = '0;
    ram_re   = 1'b0;
    ram_ra   = head;
    fin      = 1'b0;
    f_fired  = 1'b0;
    f_id_raw = '0;
    f_late   = '0;
    f_found  = 1'b0;
    f_full   = 1'b0;
    f_count  = used;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_STEP: begin
              if (used == '0) begin
                fin = 1'b1;
              end else begin
                ram_re = 1'b1;
              end
            end
            KIND_ADD: begin
              fin = 1'b1;
              if (used == CNT_W'(DEPTH)) begin
                f_full = 1'b1;
              end else begin
                ram_we  = 1'b1;
                ram_wd  = {key_in, now, period, time_t'(0)};
                f_count = used + CNT_W'(1);
              end
            end
            default: ;
          endcase
        end
      end
      ST_STEP: begin
        // head entry goes to the tail, updated if it fired
        fin      = 1'b1;
        ram_we   = 1'b1;
        ram_wd   = {r_id, step_fire ? step_due : r_due, r_per,
                    step_fire ? step_late : r_late};
        f_fired  = step_fire;
        f_id_raw = step_fire ? r_id : '0;
        f_late   = step_fire ? step_late : '0;
      end
      ST_WALK: begin
        ram_ra = rd_ptr;
        ram_re = walk_issue;
        // compaction: survivors are copied down to the write pointer
        if (rd_pend && !walk_match && kind_q == KIND_REMOVE) begin
          ram_we = 1'b1;
          ram_wa = wr_ptr;
          ram_wd = ram_rd;
        end
        fin      = !walk_issue && !rd_pend;
        f_found  = hit;
        f_late   = (kind_q == KIND_QUERY) ? hit_late : '0;
        f_id_raw = (kind_q == KIND_QUERY) ? key_q : '0;
        f_count  = (kind_q == KIND_REMOVE) ? keep : used;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  assign f_id_ext    = (ID_BITS + TASK_ID_W)'(f_id_raw);
  assign f_count_ext = (CNT_W + COUNT_W)'(f_count);

  assign out_free = !out_valid || !out_stall;
  assign load_out = out_free && (fin || state == ST_DONE);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      used      <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
      keep      <= '0;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      rd_pend   <= 1'b0;
      hit       <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (fin) begin
        used  <= f_count;
        state <= out_free ? ST_IDLE : ST_DONE;
      end
      if (state == ST_DONE && out_free) begin
        state <= ST_IDLE;
      end

      if (state == ST_STEP) begin
        head <= ptr_inc(head);
      end

      if (accept && (kind == KIND_REMOVE || kind == KIND_QUERY)) begin
        state   <= ST_WALK;
        idx     <= '0;
        keep    <= '0;
        rd_ptr  <= head;
        wr_ptr  <= head;
        rd_pend <= 1'b0;
        hit     <= 1'b0;
      end
      if (accept && kind == KIND_STEP && used != '0) begin
        state <= ST_STEP;
      end

      if (state == ST_WALK) begin
        rd_pend <= walk_issue;
        if (walk_issue) begin
          rd_ptr <= ptr_inc(rd_ptr);
          idx    <= idx + CNT_W'(1);
        end
        if (rd_pend) begin
          if (walk_match) begin
            hit <= 1'b1;
          end else begin
            wr_ptr <= ptr_inc(wr_ptr);
            keep   <= keep + CNT_W'(1);
          end
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q   <= kind;
      key_q    <= key_in;
      now_q    <= now;
      hit_late <= '0;
    end
    if (state == ST_WALK && rd_pend && walk_match) begin
      hit_late <= r_late;
    end

    if (fin && !out_free) begin
      res_fired <= f_fired;
      res_id    <= f_id_ext[TASK_ID_W-1:0];
      res_late  <= f_late;
      res_found <= f_found;
      res_full  <= f_full;
      res_count <= f_count_ext[COUNT_W-1:0];
    end

    if (load_out) begin
      if (state == ST_DONE) begin
        fired       <= res_fired;
        fired_id    <= res_id;
        lateness    <= res_late;
        found       <= res_found;
        ring_full   <= res_full;
        entry_count <= res_count;
      end else begin
        fired       <= f_fired;
        fired_id    <= f_id_ext[TASK_ID_W-1:0];
        lateness    <= f_late;
        found       <= f_found;
        ring_full   <= f_full;
        entry_count <= f_count_ext[COUNT_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/ptrs_chk.sv =====
// Port-level checks for the periodic task ring scheduler, bound to the top level.
// Depends on ptrs_pkg for the field widths.
`default_nettype none

module ptrs_chk
  import ptrs_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic [KIND_W-1:0]    kind,
  input wire logic [TIME_W-1:0]    now,
  input wire logic [TASK_ID_W-1:0] task_id,
  input wire logic [TIME_W-1:0]    period,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic                 fired,
  input wire logic [TASK_ID_W-1:0] fired_id,
  input wire logic [TIME_W-1:0]    lateness,
  input wire logic                 found,
  input wire logic                 ring_full,
  input wire logic [COUNT_W-1:0]   entry_count
);

  // no result beat straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(entry_count) && $stable(lateness)
      && $stable(fired_id))
    else $error("stalled result beat changed");

  // a firing step never reports a match or a dropped add
  a_fired_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && fired |-> !found && !ring_full)
    else $error("fired together with found or ring_full");

  // a dropped add carries nothing else but the entry count
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && ring_full |-> !fired && !found && lateness == '0 && fired_id == '0)
    else $error("ring_full beat carries other results");

endmodule

bind periodic_task_ring_scheduler ptrs_chk u_ptrs_chk (.*);

`default_nettype wire
